// ===== rtl/pfdt_pkg.sv =====
package pfdt_pkg;

   localparam int MAX_FRAMES_DEF = 1024;
   localparam int PAGE_SHIFT_DEF = 12;

   // frame_total after reset
   localparam int FRAME_TOTAL_RST = 1024;

   // first_frame + frame_count fits in this many bits
   localparam int RUN_W = 12;

   localparam logic [15:0] REFS_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      OP_MARK      = 3'd0,
      OP_REF       = 3'd1,
      OP_UNREF     = 3'd2,
      OP_LOOKUP    = 3'd3,
      OP_ADD_FREE  = 3'd4,
      OP_TAKE_FREE = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_MARK,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [3:0]  ptype;
      logic [15:0] refs;
      logic [15:0] flags;
   } entry_type;

   typedef struct packed {
      logic latch;
      logic decode;
      logic clear_step;
      logic mark_step;
      logic run_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic mark_go;
      logic run_op;
      logic mark_end;
      logic run_end;
      logic clear_end;
      logic rsp_free;
   } status_type;

endpackage

// ===== rtl/pfdt_ctrl.sv =====
module pfdt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pfdt_pkg::status_type status,
   output pfdt_pkg::cmd_type    cmd
);

   pfdt_pkg::state_type state_ff;
   pfdt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfdt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfdt_pkg::ST_CLEAR: begin
            if (status.clear_end) state_in = pfdt_pkg::ST_IDLE;
         end
         pfdt_pkg::ST_IDLE: begin
            if (req_valid) state_in = pfdt_pkg::ST_DECODE;
         end
         pfdt_pkg::ST_DECODE: begin
            if (status.mark_go) begin
               state_in = pfdt_pkg::ST_MARK;
            end else if (status.run_op) begin
               state_in = pfdt_pkg::ST_RUN;
            end else begin
               state_in = pfdt_pkg::ST_DONE;
            end
         end
         pfdt_pkg::ST_MARK: begin
            if (status.mark_end) state_in = pfdt_pkg::ST_DONE;
         end
         pfdt_pkg::ST_RUN: begin
            if (status.run_end) state_in = pfdt_pkg::ST_DONE;
         end
         pfdt_pkg::ST_DONE: begin
            if (status.rsp_free) state_in = pfdt_pkg::ST_IDLE;
         end
         default: begin
            state_in = pfdt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      case (state_ff)
         pfdt_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         pfdt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         pfdt_pkg::ST_DECODE: begin
            cmd.decode = 1'b1;
         end
         pfdt_pkg::ST_MARK: begin
            cmd.mark_step = 1'b1;
         end
         pfdt_pkg::ST_RUN: begin
            cmd.run_step = 1'b1;
         end
         pfdt_pkg::ST_DONE: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.latch, cmd.decode, cmd.clear_step, cmd.mark_step, cmd.run_step,
                cmd.load_rsp}))
      else $error("more than one datapath command active");

   a_latch_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |=> cmd.decode)
      else $error("accepted word not decoded in next cycle");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> state_ff == pfdt_pkg::ST_IDLE)
      else $error("controller not idle after result load");
`endif

endmodule

// ===== rtl/pfdt_datapath.sv =====
module pfdt_datapath #(
   parameter int MAX_FRAMES = pfdt_pkg::MAX_FRAMES_DEF,
   parameter int PAGE_SHIFT = pfdt_pkg::PAGE_SHIFT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pfdt_pkg::cmd_type    cmd,
   output pfdt_pkg::status_type status,
   input  logic                 csr_wr_en,
   input  logic [10:0]          csr_wr_data,
   input  logic [2:0]           req_operation,
   input  logic [31:0]          req_start_addr,
   input  logic [31:0]          req_end_addr,
   input  logic [9:0]           req_first_frame,
   input  logic [10:0]          req_frame_count,
   input  logic [3:0]           req_desc_type,
   input  logic [15:0]          req_ref_value,
   input  logic [15:0]          req_desc_flags,
   input  logic [10:0]          req_amount,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_found,
   output logic [9:0]           rsp_frame_index,
   output logic [3:0]           rsp_entry_type,
   output logic [15:0]          rsp_entry_refs,
   output logic [15:0]          rsp_entry_flags,
   output logic [10:0]          rsp_freed_count,
   output logic [10:0]          rsp_free_total,
   output logic                 rsp_error
);

   localparam int AW = $clog2(MAX_FRAMES);
   localparam int XW = (AW + 1 > pfdt_pkg::RUN_W) ? AW + 1 : pfdt_pkg::RUN_W;
   localparam int TOTAL_RST_I = (pfdt_pkg::FRAME_TOTAL_RST < MAX_FRAMES) ?
                                pfdt_pkg::FRAME_TOTAL_RST : MAX_FRAMES;
   localparam logic [XW-1:0] TOTAL_RST = XW'(TOTAL_RST_I);
   localparam logic [XW-1:0] MAX_W     = XW'(MAX_FRAMES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_FRAMES - 1);

   // descriptor store
   pfdt_pkg::entry_type desc_mem_ff [MAX_FRAMES];

   // latched request
   pfdt_pkg::op_type    op_ff;
   logic [31:0]         sa_ff;
   logic [31:0]         ea_ff;
   logic [9:0]          first_ff;
   logic [10:0]         count_ff;
   logic [3:0]          ptype_ff;
   logic [15:0]         refv_ff;
   logic [15:0]         flags_ff;
   logic [10:0]         amt_ff;

   logic [XW-1:0]       eff_total_ff, eff_total_in;
   logic [10:0]         free_ff, free_in;
   logic [XW-1:0]       cur_ff, cur_in;
   logic [XW-1:0]       end_ff, end_in;
   logic [10:0]         rem_ff, rem_in;
   logic                err_ff, err_in;
   logic                found_ff, found_in;
   logic [9:0]          idx_ff, idx_in;
   logic [10:0]         freed_ff, freed_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [AW-1:0]       rd_addr_ff;
   pfdt_pkg::entry_type rd_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [31:0]         start_frame;
   logic [31:0]         last_addr;
   logic [31:0]         end_frame;
   logic [31:0]         total32;
   logic                mark_empty;
   logic                start_hit;
   logic                end_over;
   logic [11:0]         free_sum;
   logic                run_out;
   logic                run_end;
   logic                run_issue;

   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   pfdt_pkg::entry_type wr_data;

   pfdt_pkg::entry_type wb_entry;
   logic                wb_write;
   logic                wb_err;
   logic                wb_freed;

   function automatic logic [31:0] req_start_addr_shift(input logic [31:0] addr);
      return addr >> PAGE_SHIFT;
   endfunction

   always_comb begin
      start_frame = req_start_addr_shift(sa_ff);
      last_addr   = ea_ff - 32'd1;
      end_frame   = req_start_addr_shift(last_addr);
      total32     = 32'(eff_total_ff);
      mark_empty  = ea_ff <= sa_ff;
      start_hit   = start_frame < total32;
      end_over    = end_frame >= total32;
      free_sum    = {1'b0, free_ff} + {1'b0, amt_ff};
      run_out     = cur_ff >= eff_total_ff;
      run_end     = (rem_ff == 11'd0) || run_out;
      run_issue   = cmd.run_step && !run_end;
   end

   always_comb begin
      status.mark_go   = cmd.decode && (op_ff == pfdt_pkg::OP_MARK) && !mark_empty &&
                         start_hit;
      status.run_op    = (op_ff == pfdt_pkg::OP_REF) || (op_ff == pfdt_pkg::OP_UNREF);
      status.mark_end  = cur_ff == end_ff;
      status.run_end   = run_end;
      status.clear_end = clr_ff == LAST_ADDR;
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // refcount update for the word read in the previous run cycle
   always_comb begin
      wb_entry = rd_data_ff;
      wb_write = 1'b0;
      wb_err   = 1'b0;
      wb_freed = 1'b0;
      if (op_ff == pfdt_pkg::OP_REF) begin
         if (rd_data_ff.refs == pfdt_pkg::REFS_MAX) begin
            wb_err = 1'b1;
         end else begin
            wb_entry.refs = rd_data_ff.refs + 16'd1;
            wb_write      = 1'b1;
         end
      end else begin
         if (rd_data_ff.refs == 16'd0) begin
            wb_err = 1'b1;
         end else begin
            wb_entry.refs = rd_data_ff.refs - 16'd1;
            wb_write      = 1'b1;
            wb_freed      = rd_data_ff.refs == 16'd1;
         end
      end
   end

   always_comb begin
      eff_total_in = eff_total_ff;
      free_in      = free_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      rem_in       = rem_ff;
      err_in       = err_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      freed_in     = freed_ff;
      clr_in       = clr_ff;
      rd_valid_in  = run_issue;

      if (csr_wr_en) begin
         eff_total_in = (XW'(csr_wr_data) >= MAX_W) ? MAX_W : XW'(csr_wr_data);
      end

      if (cmd.clear_step) begin
         clr_in = clr_ff + AW'(1);
      end

      if (cmd.latch) begin
         err_in   = 1'b0;
         found_in = 1'b0;
         idx_in   = '0;
         freed_in = '0;
      end

      if (cmd.decode) begin
         case (op_ff)
            pfdt_pkg::OP_MARK: begin
               err_in = mark_empty;
               if (!mark_empty && start_hit) begin
                  found_in = 1'b1;
                  idx_in   = start_frame[9:0];
                  cur_in   = start_frame[XW-1:0];
                  end_in   = end_over ? eff_total_ff - XW'(1) : end_frame[XW-1:0];
               end
            end
            pfdt_pkg::OP_REF, pfdt_pkg::OP_UNREF: begin
               cur_in = XW'(first_ff);
               rem_in = count_ff;
            end
            pfdt_pkg::OP_LOOKUP: begin
               if (start_hit) begin
                  found_in = 1'b1;
                  idx_in   = start_frame[9:0];
               end
            end
            pfdt_pkg::OP_ADD_FREE: begin
               if (XW'(free_sum) >= eff_total_ff) begin
                  err_in = 1'b1;
               end else begin
                  free_in = free_sum[10:0];
               end
            end
            pfdt_pkg::OP_TAKE_FREE: begin
               if (free_ff <= amt_ff) begin
                  err_in = 1'b1;
               end else begin
                  free_in = free_ff - amt_ff;
               end
            end
            default: begin
               err_in = 1'b1;
            end
         endcase
      end

      if (cmd.mark_step) begin
         cur_in = cur_ff + XW'(1);
      end

      if (cmd.run_step) begin
         if (run_issue) begin
            cur_in = cur_ff + XW'(1);
            rem_in = rem_ff - 11'd1;
         end else if (rem_ff != 11'd0) begin
            // rest of the run lies beyond the table
            err_in = 1'b1;
         end
      end

      if (rd_valid_ff) begin
         if (wb_err) err_in = 1'b1;
         if (wb_freed) freed_in = freed_ff + 11'd1;
      end
   end

   always_comb begin
      rd_en   = run_issue ||
                (cmd.decode && (op_ff == pfdt_pkg::OP_LOOKUP) && start_hit);
      rd_addr = run_issue ? cur_ff[AW-1:0] : start_frame[AW-1:0];

      wr_en   = 1'b0;
      wr_addr = rd_addr_ff;
      wr_data = wb_entry;
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (cmd.mark_step) begin
         wr_en         = 1'b1;
         wr_addr       = cur_ff[AW-1:0];
         wr_data.ptype = ptype_ff;
         wr_data.refs  = refv_ff;
         wr_data.flags = flags_ff;
      end else if (rd_valid_ff) begin
         wr_en = wb_write;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         desc_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= desc_mem_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= pfdt_pkg::op_type'(req_operation);
         sa_ff    <= req_start_addr;
         ea_ff    <= req_end_addr;
         first_ff <= req_first_frame;
         count_ff <= req_frame_count;
         ptype_ff <= req_desc_type;
         refv_ff  <= req_ref_value;
         flags_ff <= req_desc_flags;
         amt_ff   <= req_amount;
      end
      cur_ff   <= cur_in;
      end_ff   <= end_in;
      rem_ff   <= rem_in;
      err_ff   <= err_in;
      found_ff <= found_in;
      idx_ff   <= idx_in;
      freed_ff <= freed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_total_ff <= TOTAL_RST;
         free_ff      <= '0;
         clr_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         eff_total_ff <= eff_total_in;
         free_ff      <= free_in;
         clr_ff       <= clr_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // result register: hold until taken
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_found       <= found_ff;
         rsp_frame_index <= idx_ff;
         rsp_freed_count <= freed_ff;
         rsp_free_total  <= free_ff;
         rsp_error       <= err_ff;
         if ((op_ff == pfdt_pkg::OP_LOOKUP) && found_ff) begin
            rsp_entry_type  <= rd_data_ff.ptype;
            rsp_entry_refs  <= rd_data_ff.refs;
            rsp_entry_flags <= rd_data_ff.flags;
         end else begin
            rsp_entry_type  <= '0;
            rsp_entry_refs  <= '0;
            rsp_entry_flags <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_wb_follows_issue: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(cmd.run_step))
      else $error("refcount writeback without a run read");

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_step |-> (cur_ff <= end_ff) && (cur_ff < eff_total_ff))
      else $error("mark walk past its end frame");

   a_clear_no_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !rsp_valid_ff)
      else $error("result pending during clearing pass");
`endif

endmodule

// ===== rtl/page_frame_descriptor_table_unit.sv =====
// Channel   Direction  Handshake                Word
// req_*     in         req_valid / req_ready    operation, addresses, run, mark data, amount
// rsp_*     out        rsp_valid / rsp_ready    found, index, entry, freed, free total, error
// csr_*     in         csr_wr_en (no wait)      frame_total
//
// After reset the descriptor store is cleared one frame per cycle, every frame in turn,
// with req_ready low; csr writes are taken during that pass.
// One word at a time: lookup, free-total and rejected ops go from accept through decode to
// result load; mark also writes each frame in range, and reference/unreference do one
// descriptor read-modify-write per cycle plus a final run state to retire the last write.
// A result held by rsp_ready low stalls only the final load; the next word is accepted.
module page_frame_descriptor_table_unit #(
   parameter int MAX_FRAMES = pfdt_pkg::MAX_FRAMES_DEF,
   parameter int PAGE_SHIFT = pfdt_pkg::PAGE_SHIFT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_start_addr,
   input  logic [31:0] req_end_addr,
   input  logic [9:0]  req_first_frame,
   input  logic [10:0] req_frame_count,
   input  logic [3:0]  req_desc_type,
   input  logic [15:0] req_ref_value,
   input  logic [15:0] req_desc_flags,
   input  logic [10:0] req_amount,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [9:0]  rsp_frame_index,
   output logic [3:0]  rsp_entry_type,
   output logic [15:0] rsp_entry_refs,
   output logic [15:0] rsp_entry_flags,
   output logic [10:0] rsp_freed_count,
   output logic [10:0] rsp_free_total,
   output logic        rsp_error
);

   pfdt_pkg::cmd_type    cmd;
   pfdt_pkg::status_type status;

   pfdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pfdt_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_operation   (req_operation),
      .req_start_addr  (req_start_addr),
      .req_end_addr    (req_end_addr),
      .req_first_frame (req_first_frame),
      .req_frame_count (req_frame_count),
      .req_desc_type   (req_desc_type),
      .req_ref_value   (req_ref_value),
      .req_desc_flags  (req_desc_flags),
      .req_amount      (req_amount),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_frame_index (rsp_frame_index),
      .rsp_entry_type  (rsp_entry_type),
      .rsp_entry_refs  (rsp_entry_refs),
      .rsp_entry_flags (rsp_entry_flags),
      .rsp_freed_count (rsp_freed_count),
      .rsp_free_total  (rsp_free_total),
      .rsp_error       (rsp_error)
   );

endmodule
